// File: hdl/rwcs_pkg.sv
// Shared types and constants of the raycast wall column setup pipeline.
`timescale 1ns / 1ps
package rwcs_pkg;

  typedef enum logic [2:0] {
    REG_PLANE,
    REG_MIN,
    REG_EAST_W,
    REG_WEST_W,
    REG_SOUTH_W,
    REG_NORTH_W
  } reg_idx_e;

  typedef enum logic [1:0] {
    FACE_EAST,
    FACE_WEST,
    FACE_SOUTH,
    FACE_NORTH
  } face_e;

  typedef struct packed {
    logic [14:0] idx;
    logic        neg;
  } cos_req_t;

  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;
  localparam logic [30:0] Q30One    = 31'h4000_0000;

  localparam int CosSteps = 6;
  localparam int unsigned CosDiv   [CosSteps] = '{132, 90, 56, 30, 12, 2};
  localparam int unsigned CosShift [CosSteps] = '{38, 37, 36, 35, 34, 32};
  // floor(2^shift / div)
  localparam logic [31:0] CosMul [CosSteps] = '{
    32'd2082408385, 32'd1527099483, 32'd1227133513,
    32'd1145324612, 32'd1431655765, 32'd2147483648
  };

  localparam int CosLat = 2 + 3 * CosSteps + 1;
  localparam int DivLat = 17;

endpackage

// File: hdl/rwcs_cos.sv
// Pipelined quarter-wave cosine: integer Taylor series, three stages per Horner step.
`timescale 1ns / 1ps
module rwcs_cos import rwcs_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  cos_req_t           req_i,
  output logic signed [17:0] cos_o
);

  logic [45:0] xm;
  logic [61:0] x2m;
  logic [30:0] x_q;
  logic [31:0] x2s_q;
  logic [31:0] xin  [CosSteps];
  logic [30:0] rin  [CosSteps];
  logic [62:0] prod_q [CosSteps];
  logic [31:0] p    [CosSteps];
  logic [31:0] p_q  [CosSteps];
  logic [63:0] m_q  [CosSteps];
  logic [32:0] q0   [CosSteps];
  logic [39:0] rem  [CosSteps];
  logic [32:0] qc   [CosSteps];
  logic [30:0] r_d  [CosSteps];
  logic [30:0] r_q  [CosSteps];
  logic [31:0] x2a_q [CosSteps-1];
  logic [31:0] x2b_q [CosSteps-1];
  logic [31:0] x2c_q [CosSteps-1];
  logic        neg_q [CosLat-1];
  logic [31:0] rnd;
  logic [16:0] mag;
  logic signed [17:0] cos_d, cos_q;

  assign xm  = 46'(req_i.idx) * 46'(HalfPiQ30);
  assign x2m = 62'(x_q) * 62'(x_q);

  always_comb begin
    for (int k = 0; k < CosSteps; k++) begin
      xin[k] = (k == 0) ? x2s_q : x2c_q[(k == 0) ? 0 : k - 1];
      rin[k] = (k == 0) ? Q30One : r_q[(k == 0) ? 0 : k - 1];
      p[k]   = 32'(prod_q[k] >> 30);
      q0[k]  = 33'(m_q[k] >> CosShift[k]);
      rem[k] = 40'(p_q[k]) - 40'(q0[k]) * 40'(CosDiv[k]);
      qc[k]  = (rem[k] >= 40'(CosDiv[k])) ? q0[k] + 33'd1 : q0[k];
      r_d[k] = (qc[k] >= 33'(Q30One)) ? 31'd0 : 31'(33'(Q30One) - qc[k]);
    end
    rnd = 32'(r_q[CosSteps-1]) + 32'd8192;
    mag = (rnd[31:14] > 18'd65536) ? 17'd65536 : 17'(rnd[31:14]);
    cos_d = neg_q[CosLat-2] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q   <= 31'(xm >> 14);
      x2s_q <= 32'(x2m >> 30);
      for (int k = 0; k < CosSteps; k++) begin
        prod_q[k] <= 63'(xin[k]) * 63'(rin[k]);
        p_q[k]    <= p[k];
        m_q[k]    <= p[k] * CosMul[k];
        r_q[k]    <= r_d[k];
      end
      for (int k = 0; k < CosSteps - 1; k++) begin
        x2a_q[k] <= xin[k];
        x2b_q[k] <= x2a_q[k];
        x2c_q[k] <= x2b_q[k];
      end
      neg_q[0] <= req_i.neg;
      for (int i = 1; i < CosLat - 1; i++) begin
        neg_q[i] <= neg_q[i-1];
      end
      cos_q <= cos_d;
    end
  end

  assign cos_o = cos_q;

endmodule

// File: hdl/rwcs_div.sv
// Pipelined restoring divider, one quotient bit per stage, quotient saturating at 16 bits.
`timescale 1ns / 1ps
module rwcs_div import rwcs_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic [15:0] quo_o
);

  localparam int Bits = DivLat - 1;

  logic [31:0] rem_q [DivLat];
  logic [31:0] den_q [DivLat-1];
  logic [15:0] q_q   [DivLat];
  logic        sat_q [DivLat];
  logic [47:0] trial [Bits];
  logic        ge    [Bits];

  always_comb begin
    for (int s = 0; s < Bits; s++) begin
      trial[s] = {16'b0, den_q[s]} << (Bits - 1 - s);
      ge[s]    = {16'b0, rem_q[s]} >= trial[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      q_q[0]   <= '0;
      sat_q[0] <= {16'b0, num_i} >= {den_i, 16'b0};
      for (int s = 0; s < Bits; s++) begin
        rem_q[s+1] <= ge[s] ? rem_q[s] - trial[s][31:0] : rem_q[s];
        q_q[s+1]   <= q_q[s] | (16'(ge[s]) << (Bits - 1 - s));
        sat_q[s+1] <= sat_q[s];
      end
      for (int s = 1; s < DivLat - 1; s++) begin
        den_q[s] <= den_q[s-1];
      end
    end
  end

  assign quo_o = sat_q[DivLat-1] ? 16'hFFFF : q_q[DivLat-1];

endmodule

// File: hdl/raycast_wall_column_setup.sv
// Top level: wall distance, face, texture column and screen span for one ray per cycle while the output is not stalled.
`timescale 1ns / 1ps
// One item enters per cycle while the pipeline is not held.
// The 41 register stages are set by the cosine series (angle and square stages, six
// Horner steps of three stages each, one rounding stage), the distance product and
// clamp, the 17-stage height divider and the output register. When the output is held
// by out_stall_i with a result waiting, the whole pipeline holds and in_stall_o rises in
// the same cycle; otherwise items flow back to back. Configuration registers are read
// live and should be written only when the pipeline is empty.
module raycast_wall_column_setup import rwcs_pkg::*; #(
  parameter int SCREEN_HEIGHT = 1024,
  parameter int MAX_TEX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        hit_side_i,
  input  logic [31:0] side_dist_x_i,
  input  logic [31:0] side_dist_y_i,
  input  logic [31:0] delta_dist_x_i,
  input  logic [31:0] delta_dist_y_i,
  input  logic signed [17:0] ray_dir_x_i,
  input  logic signed [17:0] ray_dir_y_i,
  input  logic [15:0] ray_heading_i,
  input  logic [15:0] view_heading_i,
  input  logic [31:0] eye_x_i,
  input  logic [31:0] eye_y_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] perp_distance_o,
  output logic [1:0]  texture_face_o,
  output logic [9:0]  texture_column_o,
  output logic [15:0] column_height_o,
  output logic [9:0]  column_top_o,
  output logic [9:0]  column_bottom_o
);

  localparam int TexW       = $clog2(MAX_TEX_WIDTH + 1);
  localparam int PipeLen    = CosLat + 2 + DivLat;
  localparam int TexDly     = PipeLen - 5;
  localparam int HalfScreen = SCREEN_HEIGHT / 2;

  logic        en;
  logic [31:0] plane_q;
  logic [16:0] min_q;
  logic [10:0] tw_q [4];

  logic        vld_q [PipeLen];
  logic        out_valid_q;

  // front end
  logic [15:0] adiff;
  cos_req_t    creq;
  logic signed [32:0] dist_d;
  logic signed [17:0] dsel_d;
  face_e       face_d;
  logic        mirror_d;

  logic signed [32:0] dist_q [CosLat];
  logic signed [17:0] dsel_q;
  logic [15:0] eye16_q, eye16_q2;
  face_e       face_q, face_q2, face_q3, face_q4;
  logic        mirror_q, mirror_q2, mirror_q3, mirror_q4;
  logic signed [50:0] tprod_q;
  logic [31:0] frac_q;
  logic [TexW-1:0] width_d, width_q3, width_q4;
  logic [10:0] wsel;
  logic [31+TexW:0] colm_q;
  logic [TexW-1:0] col_raw, col_d;
  logic [TexW+1:0] tex_q [TexDly+1];

  // distance and height
  logic signed [17:0] cos_val;
  logic signed [50:0] wprod_q;
  logic [34:0] wall_raw;
  logic [16:0] minv;
  logic [34:0] wall_c;
  logic [31:0] wall_d, wall_q;
  logic [31:0] wall_dly_q [DivLat];
  logic [15:0] height;
  logic signed [17:0] top_s, bot_s;
  logic [17:0] top_c, bot_c;
  logic [TexW+9:0] col_ext;

  logic [31:0] perp_q;
  logic [1:0]  face_out_q;
  logic [9:0]  col_out_q, top_q, bot_q;
  logic [15:0] height_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= 32'd33554432;
      min_q   <= 17'd6554;
      for (int i = 0; i < 4; i++) begin
        tw_q[i] <= 11'd64;
      end
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PLANE:   plane_q  <= cfg_data_i;
        REG_MIN:     min_q    <= cfg_data_i[16:0];
        REG_EAST_W:  tw_q[0]  <= cfg_data_i[10:0];
        REG_WEST_W:  tw_q[1]  <= cfg_data_i[10:0];
        REG_SOUTH_W: tw_q[2]  <= cfg_data_i[10:0];
        REG_NORTH_W: tw_q[3]  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PipeLen; i++) begin
        vld_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < PipeLen; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      out_valid_q <= vld_q[PipeLen-1];
    end
  end

  always_comb begin
    adiff    = ray_heading_i - view_heading_i;
    creq.idx = adiff[14] ? 15'd16384 - 15'(adiff[13:0]) : 15'(adiff[13:0]);
    creq.neg = adiff[15] ^ adiff[14];
    if (hit_side_i) begin
      dist_d   = $signed({1'b0, side_dist_y_i}) - $signed({1'b0, delta_dist_y_i});
      dsel_d   = ray_dir_x_i;
      face_d   = (ray_dir_y_i < 0) ? FACE_SOUTH : FACE_NORTH;
      mirror_d = ray_dir_y_i < 0;
    end else begin
      dist_d   = $signed({1'b0, side_dist_x_i}) - $signed({1'b0, delta_dist_x_i});
      dsel_d   = ray_dir_y_i;
      face_d   = (ray_dir_x_i < 0) ? FACE_EAST : FACE_WEST;
      mirror_d = ray_dir_x_i > 0;
    end
  end

  rwcs_cos u_cos (
    .clk_i (clk_i),
    .en_i  (en),
    .req_i (creq),
    .cos_o (cos_val)
  );

  always_comb begin
    wsel = tw_q[face_q2];
    if (wsel == 11'd0) begin
      width_d = TexW'(1);
    end else if (32'(wsel) > 32'(MAX_TEX_WIDTH)) begin
      width_d = TexW'(MAX_TEX_WIDTH);
    end else begin
      width_d = TexW'(wsel);
    end
    col_raw = colm_q[31+TexW:32];
    col_d   = mirror_q4 ? width_q4 - col_raw - TexW'(1) : col_raw;
  end

  always_comb begin
    wall_raw = (wprod_q > 0) ? 35'(wprod_q[50:16]) : 35'd0;
    minv     = (min_q == 17'd0) ? 17'd1 : min_q;
    wall_c   = (wall_raw < 35'(minv)) ? 35'(minv) : wall_raw;
    wall_d   = (wall_c > 35'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : wall_c[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q[0] <= dist_d;
      for (int i = 1; i < CosLat; i++) begin
        dist_q[i] <= dist_q[i-1];
      end
      dsel_q    <= dsel_d;
      eye16_q   <= hit_side_i ? eye_x_i[15:0] : eye_y_i[15:0];
      face_q    <= face_d;
      mirror_q  <= mirror_d;
      tprod_q   <= dist_q[0] * dsel_q;
      eye16_q2  <= eye16_q;
      face_q2   <= face_q;
      mirror_q2 <= mirror_q;
      frac_q    <= {eye16_q2, 16'b0} + tprod_q[31:0];
      width_q3  <= width_d;
      face_q3   <= face_q2;
      mirror_q3 <= mirror_q2;
      colm_q    <= (32 + TexW)'(frac_q) * (32 + TexW)'(width_q3);
      width_q4  <= width_q3;
      face_q4   <= face_q3;
      mirror_q4 <= mirror_q3;
      tex_q[0]  <= {face_q4, col_d};
      for (int i = 1; i <= TexDly; i++) begin
        tex_q[i] <= tex_q[i-1];
      end
      wprod_q   <= dist_q[CosLat-1] * cos_val;
      wall_q    <= wall_d;
      wall_dly_q[0] <= wall_q;
      for (int i = 1; i < DivLat; i++) begin
        wall_dly_q[i] <= wall_dly_q[i-1];
      end
    end
  end

  rwcs_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (plane_q),
    .den_i (wall_q),
    .quo_o (height)
  );

  always_comb begin
    top_s   = $signed(18'(HalfScreen)) - $signed(18'(height[15:1]));
    bot_s   = $signed(18'(HalfScreen)) + $signed(18'(height[15:1]));
    top_c   = (top_s < 0) ? 18'd0 : 18'(top_s);
    bot_c   = (bot_s >= $signed(18'(SCREEN_HEIGHT))) ? 18'(SCREEN_HEIGHT - 1) : 18'(bot_s);
    col_ext = {10'b0, tex_q[TexDly][TexW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      perp_q     <= wall_dly_q[DivLat-1];
      face_out_q <= tex_q[TexDly][TexW+1:TexW];
      col_out_q  <= col_ext[9:0];
      height_q   <= height;
      top_q      <= top_c[9:0];
      bot_q      <= bot_c[9:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign perp_distance_o  = perp_q;
  assign texture_face_o   = face_out_q;
  assign texture_column_o = col_out_q;
  assign column_height_o  = height_q;
  assign column_top_o     = top_q;
  assign column_bottom_o  = bot_q;

  a_perp_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> perp_distance_o != 32'd0)
    else $error("zero wall distance on output");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input held with empty output");

  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[CosLat-1] |-> (cos_val <= 18'sd65536) && (cos_val >= -18'sd65536))
    else $error("cosine out of range");

endmodule
